[sv/lik_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lik_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int ISQRT_STEPS  = 32;
	localparam int ACOS_LAT     = 4 + ISQRT_STEPS + CORDIC_STEPS + 1;

	typedef logic signed [23:0] cang_t;
	typedef logic signed [25:0] angle_t;

	localparam angle_t DEG180_Q16 = 26'sd11796480;

	typedef enum logic [2:0] {
		REG_HIP_OFFSET  = 3'd0,
		REG_FRONT_UPPER = 3'd1,
		REG_FRONT_LOWER = 3'd2,
		REG_REAR_UPPER  = 3'd3,
		REG_REAR_LOWER  = 3'd4
	} reg_idx_t;

	// Arctangent of 2^-i in 1/65536 degree.
	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		logic [21:0] r;
		unique case (i)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/leg_inverse_kinematics_3dof.sv]
// Channel    Handshake                  Payload
// item       item_valid / item_stall    leg_number, foot_x, foot_y, foot_z
// result     result_valid / result_stall hip_angle, knee_angle, shoulder_angle, unreachable
// cfg        cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item enters per cycle while the result is not stalled; each result is presented
// at the end of 96 register stages.
// The latency is set by two 32-step square roots and a 20-step CORDIC in series.
// Reset clears the valid bits and the link registers; cfg_ready is always high.
// A stalled result freezes the whole pipeline, and item_stall follows it.
`timescale 1ns / 1ps
`default_nettype none

module leg_inverse_kinematics_3dof (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         leg_number,
	input  logic signed [23:0] foot_x,
	input  logic signed [23:0] foot_y,
	input  logic signed [23:0] foot_z,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [17:0] hip_angle,
	output logic signed [17:0] knee_angle,
	output logic signed [17:0] shoulder_angle,
	output logic               unreachable,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [22:0]        cfg_data
);
	import lik_pkg::*;

	localparam int S_ISQ = 3;
	localparam int S_RT  = S_ISQ + ISQRT_STEPS;
	localparam int S_KN  = S_RT + 1;
	localparam int S_AB  = S_RT + 2;
	localparam int S_CMP = S_RT + 3;
	localparam int S_RAT = 1 + CORDIC_STEPS;
	localparam int S_CRD = S_RT + CORDIC_STEPS;
	localparam int S_AC  = S_AB + ACOS_LAT;
	localparam int S_SUM = S_AC + 1;
	localparam int S_OUT = S_AC + 2;

	logic [22:0] hip_offset_q;
	logic [22:0] front_upper_q;
	logic [22:0] front_lower_q;
	logic [22:0] rear_upper_q;
	logic [22:0] rear_lower_q;

	logic en;
	logic vld_s [1:S_OUT];

	logic signed [47:0] xx_c, yy_c, zz_c;
	logic [22:0] l1_in, l2_in, l1_kn;
	logic [45:0] l3sq_c, l1sq_c, l2sq_c, l12_c;
	logic [47:0] lxz2_c;
	logic [46:0] sdp_c;

	logic [23:0] ay_s1, az_s1;
	logic [46:0] xx_s1, yy_s1, zz_s1, xx_s2;
	logic [45:0] l3sq_s1, l1sq_s1, l2sq_s1, l12_s1;
	logic signed [48:0] r2_s2;
	logic [47:0] r2_s3;

	logic [1:0]         leg_s   [1:S_AC];
	logic signed [23:0] x_s     [1:S_RT];
	logic               rneg_s  [1:S_RAT];
	logic               unr_s   [1:S_SUM];
	logic [46:0]        lsum_s  [2:S_RT];
	logic signed [47:0] ldiff_s [2:S_RT];
	logic [46:0]        kd_s    [2:S_AB];
	logic [47:0]        lxz2_s  [S_ISQ:S_RT];
	angle_t             ratio_s [S_RAT+1:S_AC];
	angle_t             hipc_s  [S_CRD+1:S_AC];
	angle_t             cxz_s   [S_CRD+1:S_AC];

	logic signed [49:0] kn_s36, sn_s36;
	logic [46:0] sdp_s36;
	logic [49:0] kabs_s37, sabs_s37;
	logic        kneg_s37, sneg_s37;
	logic [47:0] sd_s37;

	logic [30:0] lyz, lxz;
	cang_t  rat_c, hipc_c, cxz_c;
	angle_t acos_k, acos_s;
	angle_t hip_s95, knee_s95, sh_s95;
	logic signed [26:0] hip_rnd, knee_rnd, sh_rnd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hip_offset_q  <= '0;
			front_upper_q <= '0;
			front_lower_q <= '0;
			rear_upper_q  <= '0;
			rear_lower_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HIP_OFFSET:  hip_offset_q  <= cfg_data;
				REG_FRONT_UPPER: front_upper_q <= cfg_data;
				REG_FRONT_LOWER: front_lower_q <= cfg_data;
				REG_REAR_UPPER:  rear_upper_q  <= cfg_data;
				REG_REAR_LOWER:  rear_lower_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en           = !(vld_s[S_OUT] && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_s[S_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= S_OUT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= item_valid;
			for (int i = 2; i <= S_OUT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_comb begin
		xx_c   = foot_x * foot_x;
		yy_c   = foot_y * foot_y;
		zz_c   = foot_z * foot_z;
		l1_in  = leg_number[1] ? rear_upper_q : front_upper_q;
		l2_in  = leg_number[1] ? rear_lower_q : front_lower_q;
		l3sq_c = hip_offset_q * hip_offset_q;
		l1sq_c = l1_in * l1_in;
		l2sq_c = l2_in * l2_in;
		l12_c  = l1_in * l2_in;
		lxz2_c = r2_s2[47:0] + {1'b0, xx_s2};
		l1_kn  = leg_s[S_RT][1] ? rear_upper_q : front_upper_q;
		sdp_c  = l1_kn * lxz[23:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Squares and link products.
			ay_s1   <= foot_y[23] ? 24'(-foot_y) : 24'(foot_y);
			az_s1   <= foot_z[23] ? 24'(-foot_z) : 24'(foot_z);
			xx_s1   <= xx_c[46:0];
			yy_s1   <= yy_c[46:0];
			zz_s1   <= zz_c[46:0];
			l3sq_s1 <= l3sq_c;
			l1sq_s1 <= l1sq_c;
			l2sq_s1 <= l2sq_c;
			l12_s1  <= l12_c;
			leg_s[1]  <= leg_number;
			x_s[1]    <= foot_x;
			rneg_s[1] <= foot_y[23] ^ foot_z[23];

			r2_s2      <= $signed({2'b00, yy_s1}) + $signed({2'b00, zz_s1})
			              - $signed({3'b000, l3sq_s1});
			lsum_s[2]  <= {1'b0, l1sq_s1} + {1'b0, l2sq_s1};
			ldiff_s[2] <= $signed({2'b00, l1sq_s1}) - $signed({2'b00, l2sq_s1});
			kd_s[2]    <= {l12_s1, 1'b0};
			xx_s2      <= xx_s1;

			r2_s3          <= r2_s2[47:0];
			lxz2_s[S_ISQ]  <= lxz2_c;

			kn_s36  <= $signed({3'b000, lsum_s[S_RT]}) - $signed({2'b00, lxz2_s[S_RT]});
			sn_s36  <= $signed({{2{ldiff_s[S_RT][47]}}, ldiff_s[S_RT]})
			           + $signed({2'b00, lxz2_s[S_RT]});
			sdp_s36 <= sdp_c;

			kabs_s37 <= kn_s36[49] ? 50'(-kn_s36) : 50'(kn_s36);
			sabs_s37 <= sn_s36[49] ? 50'(-sn_s36) : 50'(sn_s36);
			kneg_s37 <= kn_s36[49];
			sneg_s37 <= sn_s36[49];
			sd_s37   <= {sdp_s36, 1'b0};

			ratio_s[S_RAT+1] <= rneg_s[S_RAT] ? -angle_t'(rat_c) : angle_t'(rat_c);
			hipc_s[S_CRD+1]  <= angle_t'(hipc_c);
			cxz_s[S_CRD+1]   <= angle_t'(cxz_c);

			for (int i = 2; i <= S_AC; i++) leg_s[i] <= leg_s[i-1];
			for (int i = 2; i <= S_RT; i++) x_s[i] <= x_s[i-1];
			for (int i = 2; i <= S_RAT; i++) rneg_s[i] <= rneg_s[i-1];
			for (int i = 3; i <= S_RT; i++) begin
				lsum_s[i]  <= lsum_s[i-1];
				ldiff_s[i] <= ldiff_s[i-1];
			end
			for (int i = 3; i <= S_AB; i++) kd_s[i] <= kd_s[i-1];
			for (int i = S_ISQ + 1; i <= S_RT; i++) lxz2_s[i] <= lxz2_s[i-1];
			for (int i = S_RAT + 2; i <= S_AC; i++) ratio_s[i] <= ratio_s[i-1];
			for (int i = S_CRD + 2; i <= S_AC; i++) begin
				hipc_s[i] <= hipc_s[i-1];
				cxz_s[i]  <= cxz_s[i-1];
			end

			// Unreachable flag gathers each check as its operands appear.
			unr_s[1] <= (foot_y == '0);
			for (int i = 2; i <= S_SUM; i++) begin
				if (i != S_ISQ && i != S_AB && i != S_CMP) unr_s[i] <= unr_s[i-1];
			end
			unr_s[S_ISQ] <= unr_s[S_ISQ-1] | r2_s2[48] | (lxz2_c == '0);
			unr_s[S_AB]  <= unr_s[S_KN] | (kd_s[S_KN] == '0) | (sdp_s36 == '0);
			unr_s[S_CMP] <= unr_s[S_AB] | (kabs_s37 > {3'b000, kd_s[S_AB]})
			                | (sabs_s37 > {2'b00, sd_s37});

			hip_s95  <= (leg_s[S_AC][0] ~^ leg_s[S_AC][1])
			            ? (hipc_s[S_AC] + ratio_s[S_AC]) : (hipc_s[S_AC] - ratio_s[S_AC]);
			knee_s95 <= DEG180_Q16 - acos_k;
			sh_s95   <= acos_s - cxz_s[S_AC];

			hip_angle      <= unr_s[S_SUM] ? '0 : hip_rnd[25:8];
			knee_angle     <= unr_s[S_SUM] ? '0 : knee_rnd[25:8];
			shoulder_angle <= unr_s[S_SUM] ? '0 : sh_rnd[25:8];
			unreachable    <= unr_s[S_SUM];
		end
	end

	assign hip_rnd  = {hip_s95[25], hip_s95} + 27'sd128;
	assign knee_rnd = {knee_s95[25], knee_s95} + 27'sd128;
	assign sh_rnd   = {sh_s95[25], sh_s95} + 27'sd128;

	lik_isqrt u_isqrt_lyz (
		.clk  (clk),
		.en   (en),
		.arg  ({14'd0, r2_s3}),
		.root (lyz)
	);

	lik_isqrt u_isqrt_lxz (
		.clk  (clk),
		.en   (en),
		.arg  ({14'd0, lxz2_s[S_ISQ]}),
		.root (lxz)
	);

	lik_cordic u_cordic_ratio (
		.clk   (clk),
		.en    (en),
		.yv    ($signed({9'd0, az_s1})),
		.xv    ({7'd0, ay_s1}),
		.angle (rat_c)
	);

	lik_cordic u_cordic_hip (
		.clk   (clk),
		.en    (en),
		.yv    ($signed({2'b00, lyz})),
		.xv    ({8'd0, hip_offset_q}),
		.angle (hipc_c)
	);

	lik_cordic u_cordic_xz (
		.clk   (clk),
		.en    (en),
		.yv    ($signed({{9{x_s[S_RT][23]}}, x_s[S_RT]})),
		.xv    (lyz),
		.angle (cxz_c)
	);

	lik_acos u_acos_knee (
		.clk     (clk),
		.en      (en),
		.num_mag (kabs_s37),
		.den     ({1'b0, kd_s[S_AB]}),
		.num_neg (kneg_s37),
		.angle   (acos_k)
	);

	lik_acos u_acos_shoulder (
		.clk     (clk),
		.en      (en),
		.num_mag (sabs_s37),
		.den     (sd_s37),
		.num_neg (sneg_s37),
		.angle   (acos_s)
	);

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && unreachable |->
			hip_angle == '0 && knee_angle == '0 && shoulder_angle == '0)
		else $error("unreachable result carries nonzero angles");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	a_knee_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !unreachable |-> !knee_angle[17])
		else $error("knee angle negative");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(unr_s[S_SUM]) && $stable(vld_s[S_SUM]))
		else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

[sv/lik_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module lik_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] arg,
	output logic [30:0] root
);
	import lik_pkg::*;

	logic [63:0] v_s [1:ISQRT_STEPS-1];
	logic [63:0] r_s [1:ISQRT_STEPS];

	genvar k;
	generate
		for (k = 0; k < ISQRT_STEPS; k++) begin : g_step
			logic [63:0] cur_v;
			logic [63:0] cur_r;
			logic [63:0] bit_w;
			logic [63:0] trial;
			logic        take;

			if (k == 0) begin : g_first
				assign cur_v = {2'b00, arg};
				assign cur_r = '0;
			end else begin : g_next
				assign cur_v = v_s[k];
				assign cur_r = r_s[k];
			end

			assign bit_w = 64'd1 << (62 - 2 * k);
			assign trial = cur_r + bit_w;
			assign take  = (cur_v >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k+1] <= take ? ((cur_r >> 1) + bit_w) : (cur_r >> 1);
				end
			end

			if (k < ISQRT_STEPS - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						v_s[k+1] <= take ? (cur_v - trial) : cur_v;
					end
				end
			end
		end
	endgenerate

	assign root = r_s[ISQRT_STEPS][30:0];

endmodule

`default_nettype wire

[sv/lik_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module lik_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] yv,
	input  logic        [30:0] xv,
	output lik_pkg::cang_t     angle
);
	import lik_pkg::*;

	localparam int DW = 50;

	logic signed [DW-1:0] x_s [1:CORDIC_STEPS-1];
	logic signed [DW-1:0] y_s [1:CORDIC_STEPS-1];
	cang_t                a_s [1:CORDIC_STEPS];

	genvar k;
	generate
		for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
			logic signed [DW-1:0] cx;
			logic signed [DW-1:0] cy;
			cang_t                ca;
			cang_t                tab;
			logic                 pos;

			if (k == 0) begin : g_first
				assign cx = $signed({3'b000, xv, 16'h0000});
				assign cy = $signed({yv[32], yv, 16'h0000});
				assign ca = '0;
			end else begin : g_next
				assign cx = x_s[k];
				assign cy = y_s[k];
				assign ca = a_s[k];
			end

			assign tab = $signed({2'b00, atan_q16(5'(k))});
			assign pos = ~cy[DW-1] & (|cy);

			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k+1] <= pos ? (ca + tab) : (ca - tab);
				end
			end

			if (k < CORDIC_STEPS - 1) begin : g_rot
				always_ff @(posedge clk) begin
					if (en) begin
						x_s[k+1] <= pos ? (cx + (cy >>> k)) : (cx - (cy >>> k));
						y_s[k+1] <= pos ? (cy - (cx >>> k)) : (cy + (cx >>> k));
					end
				end
			end
		end
	endgenerate

	assign angle = a_s[CORDIC_STEPS];

endmodule

`default_nettype wire

[sv/lik_acos.sv]
`timescale 1ns / 1ps
`default_nettype none

module lik_acos (
	input  logic           clk,
	input  logic           en,
	input  logic [49:0]    num_mag,
	input  logic [47:0]    den,
	input  logic           num_neg,
	output lik_pkg::angle_t angle
);
	import lik_pkg::*;

	localparam int S_RT = 4 + ISQRT_STEPS;
	localparam int S_CR = S_RT + CORDIC_STEPS;

	logic [4:0]  sh_c;
	logic [4:0]  sh_s1;
	logic [47:0] d_s1;
	logic [49:0] m_s1;
	logic [30:0] d_s2;
	logic [61:0] dd_s3;
	logic [61:0] mm_s3;
	logic [61:0] diff_s4;
	logic [30:0] m_s [2:S_RT];
	logic        neg_s [1:S_CR];
	logic [30:0] root;
	cang_t       cord;
	angle_t      cord_ext;
	angle_t      angle_s57;

	always_comb begin
		sh_c = '0;
		for (int j = 31; j <= 47; j++) begin
			if (den[j]) begin
				sh_c = 5'(j - 30);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s1 <= sh_c;
			d_s1  <= den;
			m_s1  <= num_mag;
			d_s2  <= 31'(d_s1 >> sh_s1);
			m_s[2] <= 31'(m_s1 >> sh_s1);
			dd_s3 <= 62'(d_s2 * d_s2);
			mm_s3 <= 62'(m_s[2] * m_s[2]);
			diff_s4 <= dd_s3 - mm_s3;
			for (int i = 3; i <= S_RT; i++) begin
				m_s[i] <= m_s[i-1];
			end
			neg_s[1] <= num_neg;
			for (int i = 2; i <= S_CR; i++) begin
				neg_s[i] <= neg_s[i-1];
			end
			angle_s57 <= neg_s[S_CR] ? (DEG180_Q16 - cord_ext) : cord_ext;
		end
	end

	lik_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.arg  (diff_s4),
		.root (root)
	);

	lik_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.yv    ($signed({2'b00, root})),
		.xv    (m_s[S_RT]),
		.angle (cord)
	);

	assign cord_ext = angle_t'(cord);
	assign angle    = angle_s57;

endmodule

`default_nettype wire

[verif/leg_inverse_kinematics_3dof_tb.sv]
`timescale 1ns / 1ps

module leg_inverse_kinematics_3dof_tb;
	import lik_pkg::*;

	localparam longint ANGLE_180 = 180 * 65536;
	localparam logic [2:0] REG_SPARE = 3'd5;
	localparam longint ATAN_DEG[20] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	typedef struct packed {
		logic signed [17:0] hip;
		logic signed [17:0] knee;
		logic signed [17:0] shoulder;
		logic               unreach;
	} joint_t;

	typedef struct {
		logic [1:0]         leg;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		bit                 typed;
		joint_t             angles;
	} foot_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] leg_number = '0;
	logic signed [23:0] foot_x = '0;
	logic signed [23:0] foot_y = '0;
	logic signed [23:0] foot_z = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [17:0] hip_angle;
	logic signed [17:0] knee_angle;
	logic signed [17:0] shoulder_angle;
	logic unreachable;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [22:0] cfg_data = '0;

	longint link_len[5];
	joint_t angles_due[$];
	int mismatches = 0;
	int results_seen = 0;
	int burst_left = 0;
	bit hold_done = 0;

	always #1 clk = ~clk;

	leg_inverse_kinematics_3dof u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.leg_number(leg_number), .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z),
		.result_valid(result_valid), .result_stall(result_stall),
		.hip_angle(hip_angle), .knee_angle(knee_angle),
		.shoulder_angle(shoulder_angle), .unreachable(unreachable),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint atan2_deg(longint yv, longint xv);
		longint xs = xv * 65536;
		longint ys = yv * 65536;
		longint a = 0;
		longint dx, dy;
		for (int i = 0; i < 20; i++) begin
			dx = ys >>> i;
			dy = xs >>> i;
			if (ys > 0) begin
				xs += dx; ys -= dy; a += ATAN_DEG[i];
			end else begin
				xs -= dx; ys += dy; a -= ATAN_DEG[i];
			end
		end
		return a;
	endfunction

	function automatic longint acos_deg(longint num, longint den);
		longint unsigned m = (num < 0) ? -num : num;
		longint unsigned d = den;
		longint a;
		while (d >= (64'd1 << 31)) begin
			d >>= 1;
			m >>= 1;
		end
		a = atan2_deg(int_sqrt(d * d - m * m), longint'(m));
		return (num < 0) ? ANGLE_180 - a : a;
	endfunction

	function automatic logic signed [17:0] to_out(longint q);
		longint r = (q + 128) >>> 8;
		return r[17:0];
	endfunction

	function automatic joint_t solve_leg(logic [1:0] leg, longint x, longint y, longint z);
		joint_t o = '{hip: '0, knee: '0, shoulder: '0, unreach: 1'b1};
		longint l3 = link_len[REG_HIP_OFFSET];
		longint l1 = (leg < 2) ? link_len[REG_FRONT_UPPER] : link_len[REG_REAR_UPPER];
		longint l2 = (leg < 2) ? link_len[REG_FRONT_LOWER] : link_len[REG_REAR_LOWER];
		longint r2, lyz, lxz2, lxz, kn, kd, sn, sd, ratio, hip, knee, sh;
		if (y == 0) return o;
		r2 = y * y + z * z - l3 * l3;
		if (r2 < 0) return o;
		lxz2 = r2 + x * x;
		if (lxz2 == 0) return o;
		lyz = int_sqrt(r2);
		lxz = int_sqrt(lxz2);
		kn = l1 * l1 + l2 * l2 - lxz2;
		kd = 2 * l1 * l2;
		sn = l1 * l1 + lxz2 - l2 * l2;
		sd = 2 * l1 * lxz;
		if (kd == 0 || sd == 0) return o;
		if (((kn < 0) ? -kn : kn) > kd) return o;
		if (((sn < 0) ? -sn : sn) > sd) return o;
		ratio = atan2_deg((z < 0) ? -z : z, (y < 0) ? -y : y);
		if ((y < 0) != (z < 0)) ratio = -ratio;
		hip = atan2_deg(lyz, l3);
		hip = (leg == 0 || leg == 3) ? hip + ratio : hip - ratio;
		knee = ANGLE_180 - acos_deg(kn, kd);
		sh = acos_deg(sn, sd) - atan2_deg(x, lyz);
		o.hip = to_out(hip);
		o.knee = to_out(knee);
		o.shoulder = to_out(sh);
		o.unreach = 1'b0;
		return o;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [22:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < REG_SPARE) link_len[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_links(logic [22:0] off, logic [22:0] fu, logic [22:0] fl,
			logic [22:0] ru, logic [22:0] rl);
		write_reg(REG_HIP_OFFSET, off);
		write_reg(REG_FRONT_UPPER, fu);
		write_reg(REG_FRONT_LOWER, fl);
		write_reg(REG_REAR_UPPER, ru);
		write_reg(REG_REAR_LOWER, rl);
	endtask

	task automatic send_foot(logic [1:0] leg, logic signed [23:0] x, logic signed [23:0] y,
			logic signed [23:0] z, bit typed, joint_t typed_angles);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		leg_number <= leg;
		foot_x <= x;
		foot_y <= y;
		foot_z <= z;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		angles_due.push_back(typed ? typed_angles : solve_leg(leg, x, y, z));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_random(int count);
		longint span, x, y, z;
		int kind;
		joint_t none = '0;
		span = link_len[REG_HIP_OFFSET] + link_len[REG_FRONT_UPPER] + link_len[REG_FRONT_LOWER];
		if (span > 8388607) span = 8388607;
		if (span < 16) span = 16;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				x = longint'($urandom_range(0, 2 * span)) - span;
				y = longint'($urandom_range(0, 2 * span)) - span;
				z = longint'($urandom_range(0, 2 * span)) - span;
			end else if (kind < 9) begin
				x = $signed($urandom() & 32'hFFFFFF) <<< 8 >>> 8;
				y = $signed($urandom() & 32'hFFFFFF) <<< 8 >>> 8;
				z = $signed($urandom() & 32'hFFFFFF) <<< 8 >>> 8;
			end else begin
				x = longint'($urandom_range(0, 2 * span)) - span;
				y = $urandom_range(0, 1) ? 0 : link_len[REG_HIP_OFFSET];
				z = 0;
			end
			send_foot(2'($urandom_range(0, 3)), x[23:0], y[23:0], z[23:0], 1'b0, none);
		end
	endtask

	always @(posedge clk) begin
		joint_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{hip: hip_angle, knee: knee_angle, shoulder: shoulder_angle,
				unreach: unreachable};
			results_seen++;
			if (angles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer %p", got);
			end else begin
				want = angles_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	initial begin
		int mode = 0;
		int mode_left = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 300) begin
				hold_done = 1;
				result_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 60);
			end
			mode_left--;
			case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 9) < 3);
				default: result_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	initial begin
		#2000000;
		$display("leg_inverse_kinematics_3dof test failed");
		$finish;
	end

	initial begin
		foot_row_t rows[$];
		joint_t none = '0;
		joint_t off = '{hip: '0, knee: '0, shoulder: '0, unreach: 1'b1};
		for (int i = 0; i < 5; i++) link_len[i] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_random(20);
		wait_idle();

		for (int k = 0; k < 3; k++) write_reg(REG_SPARE + 3'(k), 23'h7FFFFF);
		load_links(23'd768, 23'd12800, 23'd15360, 23'd14080, 23'd16640);

		rows = '{
			'{2'd0, 24'sd1000, 24'sd0, 24'sd500, 1'b1, off},
			'{2'd1, 24'sd0, 24'sd1, 24'sd0, 1'b1, off},
			'{2'd2, 24'sd0, 24'sd768, 24'sd0, 1'b1, off},
			'{2'd3, 24'sd0, -24'sd768, 24'sd0, 1'b1, off},
			'{2'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, off},
			'{2'd3, -24'sh800000, -24'sh800000, -24'sh800000, 1'b1, off},
			'{2'd1, 24'sh7FFFFF, -24'sh800000, 24'sd0, 1'b1, off},
			'{2'd0, 24'sd1000, 24'sd768, 24'sd0, 1'b0, none},
			'{2'd1, -24'sd1000, 24'sd768, 24'sd0, 1'b0, none},
			'{2'd0, 24'sd2560, 24'sd20000, 24'sd5000, 1'b0, none},
			'{2'd1, 24'sd2560, 24'sd20000, 24'sd5000, 1'b0, none},
			'{2'd2, 24'sd2560, 24'sd20000, 24'sd5000, 1'b0, none},
			'{2'd3, 24'sd2560, 24'sd20000, 24'sd5000, 1'b0, none},
			'{2'd0, -24'sd3000, -24'sd18000, 24'sd6000, 1'b0, none},
			'{2'd1, 24'sd3000, 24'sd18000, -24'sd6000, 1'b0, none},
			'{2'd2, -24'sd8000, -24'sd15000, -24'sd9000, 1'b0, none},
			'{2'd3, 24'sd0, 24'sd27000, 24'sd0, 1'b0, none},
			'{2'd0, 24'sd0, 24'sd28928, 24'sd0, 1'b0, none},
			'{2'd2, 24'sd100, 24'sd3000, 24'sd0, 1'b0, none},
			'{2'd1, 24'sd0, 24'sd769, 24'sd0, 1'b0, none}
		};
		foreach (rows[i])
			send_foot(rows[i].leg, rows[i].x, rows[i].y, rows[i].z, rows[i].typed,
				rows[i].angles);
		send_random(500);
		wait_idle();

		load_links(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
		send_random(250);
		wait_idle();

		load_links(23'd0, 23'd25600, 23'd20000, 23'd1, 23'd1);
		send_random(250);
		wait_idle();

		load_links(23'd2000, 23'd300000, 23'd250000, 23'd0, 23'd180000);
		send_random(300);
		wait_idle();

		load_links(23'd5120, 23'd12800, 23'd12800, 23'd20480, 23'd25600);
		send_random(300);
		wait_idle();

		if (mismatches == 0 && angles_due.size() == 0) begin
			$display("leg_inverse_kinematics_3dof test passed");
		end else begin
			$display("leg_inverse_kinematics_3dof test failed");
		end
		$finish;
	end

endmodule
